// ===== rtl/vpv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpv_pkg: voice pan/volume calculator shared types and constants
// Item structs, gain and pan constants, reciprocal multipliers for the
// constant divisions, and the pan gain helpers.
// ----------------------------------------------------------------------------
package vpv_pkg;

    localparam logic [6:0]  GAIN_MAX   = 7'd127;
    localparam logic [13:0] SQ127      = 14'h3F01;
    localparam logic [5:0]  PAN_DIV    = 6'h3F;
    localparam logic [6:0]  PAN_CENTER = 7'h40;
    localparam logic [13:0] FULL_SCALE = 14'h3FFF;

    // floor(x / d) == (x * ceil(2^s / d)) >> s for x < 2^n, s = n + ceil(log2 d)
    localparam int          DIV127_A_SHIFT = 21;   // 14-bit dividend
    localparam logic [14:0] DIV127_A_M =
        15'(((64'd1 << DIV127_A_SHIFT) + 64'(GAIN_MAX) - 64'd1) / 64'(GAIN_MAX));

    localparam int          DIV127_B_SHIFT = 28;   // 21-bit dividend
    localparam logic [21:0] DIV127_B_M =
        22'(((64'd1 << DIV127_B_SHIFT) + 64'(GAIN_MAX) - 64'd1) / 64'(GAIN_MAX));

    localparam int          DIV16129_SHIFT = 42;   // 28-bit dividend
    localparam logic [28:0] DIV16129_M =
        29'(((64'd1 << DIV16129_SHIFT) + 64'(SQ127) - 64'd1) / 64'(SQ127));

    localparam int          DIV63_SHIFT = 26;      // 20-bit dividend
    localparam logic [20:0] DIV63_M =
        21'(((64'd1 << DIV63_SHIFT) + 64'(PAN_DIV) - 64'd1) / 64'(PAN_DIV));

    localparam int          DIV16383_SHIFT = 42;   // 28-bit dividend
    localparam logic [28:0] DIV16383_M =
        29'(((64'd1 << DIV16383_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

    typedef struct packed {
        logic [4:0] voice_index;
        logic [6:0] voice_volume;
        logic [6:0] note_volume;
        logic [6:0] master_volume;
        logic [6:0] program_volume;
        logic [6:0] tone_volume;
        logic [6:0] tone_pan;
        logic [6:0] program_pan;
        logic [6:0] call_pan;
        logic [6:0] score_left;
        logic [6:0] score_right;
    } vpv_in_t;

    typedef struct packed {
        logic [4:0]  out_voice;
        logic [13:0] left_register;
        logic [13:0] right_register;
    } vpv_out_t;

    typedef struct packed {
        logic [4:0]  voice;
        logic [13:0] base;
        logic [6:0]  tone_pan;
        logic [6:0]  program_pan;
        logic [6:0]  call_pan;
        logic [6:0]  score_left;
        logic [6:0]  score_right;
    } vpv_base_t;

    typedef struct packed {
        logic [4:0]  voice;
        logic [13:0] left;
        logic [13:0] right;
    } vpv_side_t;

    // left side keeps (127 - pan) / 63 when pan is right of center
    function automatic logic [5:0] pan_left_gain(input logic [6:0] pan);
        logic [6:0] rest;
        rest = GAIN_MAX - pan;
        if (pan >= PAN_CENTER)
            return rest[5:0];
        else
            return PAN_DIV;
    endfunction

    // right side keeps pan / 63 when pan is left of center
    function automatic logic [5:0] pan_right_gain(input logic [6:0] pan);
        if (pan >= PAN_CENTER)
            return PAN_DIV;
        else
            return pan[5:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vpv_gain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpv_gain: gain product pipeline
// Seven stages chain the voice, note, master, program and tone gains into
// the base volume, one multiplier per stage.
// ----------------------------------------------------------------------------
module vpv_gain import vpv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  vpv_in_t   item,
    output logic      base_valid,
    input  logic      base_ready,
    output vpv_base_t base
);

    localparam int STAGES = 7;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    vpv_in_t prm_reg  [STAGES];
    vpv_in_t prm_next [STAGES];

    logic [13:0] a_reg,    a_next;
    logic [6:0]  b_reg,    b_next;
    logic [27:0] d_reg,    d_next;
    logic [13:0] e_reg,    e_next;
    logic [20:0] f_reg,    f_next;
    logic [27:0] g_reg,    g_next;
    logic [13:0] base_reg, base_next;

    logic [6:0]  note_eff;
    logic [28:0] b_prod;
    logic [13:0] bm;
    logic [56:0] e_prod;
    logic [56:0] base_prod;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || base_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = {valid_reg[STAGES-2:0], item_valid};
        prm_next[0] = item;
        for (int k = 1; k < STAGES; k++)
        begin
            prm_next[k] = prm_reg[k-1];
        end
    end

    always_comb
    begin
        note_eff  = (item.note_volume == 7'd0) ? 7'd1 : item.note_volume;
        a_next    = {7'd0, item.voice_volume} * {7'd0, note_eff};
        b_prod    = {15'd0, a_reg} * {14'd0, DIV127_A_M};
        b_next    = b_prod[DIV127_A_SHIFT+6:DIV127_A_SHIFT];
        bm        = {7'd0, b_reg} * {7'd0, prm_reg[1].master_volume};
        d_next    = {bm, 14'd0} - {14'd0, bm};
        e_prod    = {29'd0, d_reg} * {28'd0, DIV16129_M};
        e_next    = e_prod[DIV16129_SHIFT+13:DIV16129_SHIFT];
        f_next    = {7'd0, e_reg} * {14'd0, prm_reg[3].program_volume};
        g_next    = {7'd0, f_reg} * {21'd0, prm_reg[4].tone_volume};
        base_prod = {29'd0, g_reg} * {28'd0, DIV16129_M};
        base_next = base_prod[DIV16129_SHIFT+13:DIV16129_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                    valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
                prm_reg[k] <= prm_next[k];
        end
        if (adv[0]) a_reg    <= a_next;
        if (adv[1]) b_reg    <= b_next;
        if (adv[2]) d_reg    <= d_next;
        if (adv[3]) e_reg    <= e_next;
        if (adv[4]) f_reg    <= f_next;
        if (adv[5]) g_reg    <= g_next;
        if (adv[6]) base_reg <= base_next;
    end

    assign item_stall       = !adv[0];
    assign base_valid       = valid_reg[STAGES-1];
    assign base.voice       = prm_reg[STAGES-1].voice_index;
    assign base.base        = base_reg;
    assign base.tone_pan    = prm_reg[STAGES-1].tone_pan;
    assign base.program_pan = prm_reg[STAGES-1].program_pan;
    assign base.call_pan    = prm_reg[STAGES-1].call_pan;
    assign base.score_left  = prm_reg[STAGES-1].score_left;
    assign base.score_right = prm_reg[STAGES-1].score_right;

endmodule
`default_nettype wire

// ===== rtl/vpv_pan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpv_pan: left/right split and pan attenuation
// Splits the base volume by the score channel volumes, then applies tone,
// program and call pan, each as a multiply stage and a divide-by-63 stage.
// ----------------------------------------------------------------------------
module vpv_pan import vpv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      base_valid,
    output logic      base_ready,
    input  vpv_base_t base,
    output logic      side_valid,
    input  logic      side_ready,
    output vpv_side_t side
);

    localparam int PASSES = 3;
    localparam int STAGES = 2 + 2 * PASSES;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    vpv_base_t meta_reg  [STAGES];
    vpv_base_t meta_next [STAGES];

    logic [20:0] ls_reg, ls_next, rs_reg, rs_next;
    logic [13:0] l1_reg, l1_next, r1_reg, r1_next;
    logic [42:0] ls_prod, rs_prod;

    logic [19:0] lp_reg  [PASSES];
    logic [19:0] lp_next [PASSES];
    logic [19:0] rp_reg  [PASSES];
    logic [19:0] rp_next [PASSES];
    logic [13:0] lq_reg  [PASSES];
    logic [13:0] lq_next [PASSES];
    logic [13:0] rq_reg  [PASSES];
    logic [13:0] rq_next [PASSES];
    logic [40:0] lq_prod [PASSES];
    logic [40:0] rq_prod [PASSES];
    logic [6:0]  pan_sel [PASSES];
    logic [13:0] l_in    [PASSES];
    logic [13:0] r_in    [PASSES];

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || side_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = {valid_reg[STAGES-2:0], base_valid};
        meta_next[0] = base;
        for (int k = 1; k < STAGES; k++)
        begin
            meta_next[k] = meta_reg[k-1];
        end
    end

    always_comb
    begin
        ls_next = {7'd0, base.base} * {14'd0, base.score_left};
        rs_next = {7'd0, base.base} * {14'd0, base.score_right};
        ls_prod = {22'd0, ls_reg} * {21'd0, DIV127_B_M};
        rs_prod = {22'd0, rs_reg} * {21'd0, DIV127_B_M};
        l1_next = ls_prod[DIV127_B_SHIFT+13:DIV127_B_SHIFT];
        r1_next = rs_prod[DIV127_B_SHIFT+13:DIV127_B_SHIFT];

        pan_sel[0] = meta_reg[1].tone_pan;
        pan_sel[1] = meta_reg[3].program_pan;
        pan_sel[2] = (meta_reg[5].call_pan == 7'd0) ? 7'd1 : meta_reg[5].call_pan;
        l_in[0] = l1_reg;
        r_in[0] = r1_reg;
        for (int i = 1; i < PASSES; i++)
        begin
            l_in[i] = lq_reg[i-1];
            r_in[i] = rq_reg[i-1];
        end
        for (int i = 0; i < PASSES; i++)
        begin
            lp_next[i] = {6'd0, l_in[i]} * {14'd0, pan_left_gain(pan_sel[i])};
            rp_next[i] = {6'd0, r_in[i]} * {14'd0, pan_right_gain(pan_sel[i])};
            lq_prod[i] = {21'd0, lp_reg[i]} * {20'd0, DIV63_M};
            rq_prod[i] = {21'd0, rp_reg[i]} * {20'd0, DIV63_M};
            lq_next[i] = lq_prod[i][DIV63_SHIFT+13:DIV63_SHIFT];
            rq_next[i] = rq_prod[i][DIV63_SHIFT+13:DIV63_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                    valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
                meta_reg[k] <= meta_next[k];
        end
        if (adv[0])
        begin
            ls_reg <= ls_next;
            rs_reg <= rs_next;
        end
        if (adv[1])
        begin
            l1_reg <= l1_next;
            r1_reg <= r1_next;
        end
        for (int i = 0; i < PASSES; i++)
        begin
            if (adv[2 + 2 * i])
            begin
                lp_reg[i] <= lp_next[i];
                rp_reg[i] <= rp_next[i];
            end
            if (adv[3 + 2 * i])
            begin
                lq_reg[i] <= lq_next[i];
                rq_reg[i] <= rq_next[i];
            end
        end
    end

    assign base_ready = adv[0];
    assign side_valid = valid_reg[STAGES-1];
    assign side.voice = meta_reg[STAGES-1].voice;
    assign side.left  = lq_reg[PASSES-1];
    assign side.right = rq_reg[PASSES-1];

endmodule
`default_nettype wire

// ===== rtl/vpv_square.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpv_square: mono merge and squared-law register values
// Three stages: mono select, square, divide by 16383. The last stage is
// the result register.
// ----------------------------------------------------------------------------
module vpv_square import vpv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mono_mode,
    input  logic      side_valid,
    output logic      side_ready,
    input  vpv_side_t side,
    output logic      result_valid,
    input  logic      result_stall,
    output vpv_out_t  result
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    logic [4:0] voice_reg  [STAGES];
    logic [4:0] voice_next [STAGES];
    logic       mono_q_reg  [STAGES];
    logic       mono_q_next [STAGES];

    logic [13:0] l0_reg, l0_next, r0_reg, r0_next;
    logic [27:0] sql_reg, sql_next, sqr_reg, sqr_next;
    logic [13:0] lres_reg, lres_next, rres_reg, rres_next;
    logic [13:0] louder;
    logic [56:0] l_prod, r_prod;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !result_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next     = {valid_reg[STAGES-2:0], side_valid};
        voice_next[0]  = side.voice;
        mono_q_next[0] = mono_mode;
        for (int k = 1; k < STAGES; k++)
        begin
            voice_next[k]  = voice_reg[k-1];
            mono_q_next[k] = mono_q_reg[k-1];
        end
    end

    always_comb
    begin
        louder    = (side.left >= side.right) ? side.left : side.right;
        l0_next   = mono_mode ? louder : side.left;
        r0_next   = mono_mode ? louder : side.right;
        sql_next  = {14'd0, l0_reg} * {14'd0, l0_reg};
        sqr_next  = {14'd0, r0_reg} * {14'd0, r0_reg};
        l_prod    = {29'd0, sql_reg} * {28'd0, DIV16383_M};
        r_prod    = {29'd0, sqr_reg} * {28'd0, DIV16383_M};
        lres_next = l_prod[DIV16383_SHIFT+13:DIV16383_SHIFT];
        rres_next = r_prod[DIV16383_SHIFT+13:DIV16383_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                    valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                voice_reg[k]  <= voice_next[k];
                mono_q_reg[k] <= mono_q_next[k];
            end
        end
        if (adv[0])
        begin
            l0_reg <= l0_next;
            r0_reg <= r0_next;
        end
        if (adv[1])
        begin
            sql_reg <= sql_next;
            sqr_reg <= sqr_next;
        end
        if (adv[2])
        begin
            lres_reg <= lres_next;
            rres_reg <= rres_next;
        end
    end

    assign side_ready            = adv[0];
    assign result_valid          = valid_reg[STAGES-1];
    assign result.out_voice      = voice_reg[STAGES-1];
    assign result.left_register  = lres_reg;
    assign result.right_register = rres_reg;

    // mono items leave with equal sides
    a_mono_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && mono_q_reg[2]) |-> (lres_reg == rres_reg))
        else $error("mono item with unequal sides");

    // blocked square stage keeps its item
    a_square_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[1] && !adv[1]) |=> (valid_reg[1] && $stable(sql_reg)))
        else $error("square stage lost a blocked item");

    // reciprocal divide gives the true quotient
    a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[1] && adv[2]) |=>
        (({15'd0, lres_reg} * {15'd0, FULL_SCALE}) <= {1'b0, $past(sql_reg)}) &&
        ({1'b0, $past(sql_reg)} < (({15'd0, lres_reg} + 29'd1) * {15'd0, FULL_SCALE})))
        else $error("divide by full scale is off");

endmodule
`default_nettype wire

// ===== rtl/voice_pan_volume_calc_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// voice_pan_volume_calc_unit: voice left/right volume register calculator
// Turns one voice's gain and pan parameters into its squared-law left and
// right volume register values.
//
// Input channel item/item_valid/item_stall takes one voice per item; the
// result channel result/result_valid/result_stall gives one item per input,
// in order. cfg_write with cfg_data sets mono mode; write it only while idle.
// There are 18 register stages: 7 gain, 8 split and pan, 3 square. The item
// enters the first at its accepting edge, and result_valid rises once it has
// reached the last. Throughput is one item per cycle while result_stall is low,
// each stage holding at most one multiplier or reciprocal-multiply divide.
// Each stage advances when it is empty or the one after it advances, so
// bubbles close up: while the result waits under result_stall, new items
// are taken until the pipeline is full, then item_stall rises.
// Reset empties the pipeline and clears mono mode; no result is lost or
// repeated across a stall.
// ----------------------------------------------------------------------------
module voice_pan_volume_calc_unit import vpv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_write,
    input  logic     cfg_data,
    input  logic     item_valid,
    output logic     item_stall,
    input  vpv_in_t  item,
    output logic     result_valid,
    input  logic     result_stall,
    output vpv_out_t result
);

    logic      mono_reg;
    logic      mono_next;
    logic      base_valid;
    logic      base_ready;
    vpv_base_t base;
    logic      side_valid;
    logic      side_ready;
    vpv_side_t side;

    assign mono_next = cfg_write ? cfg_data : mono_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mono_reg <= 1'b0;
        else
            mono_reg <= mono_next;
    end

    vpv_gain u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .base_valid (base_valid),
        .base_ready (base_ready),
        .base       (base)
    );

    vpv_pan u_pan (
        .clk        (clk),
        .rst_n      (rst_n),
        .base_valid (base_valid),
        .base_ready (base_ready),
        .base       (base),
        .side_valid (side_valid),
        .side_ready (side_ready),
        .side       (side)
    );

    vpv_square u_square (
        .clk          (clk),
        .rst_n        (rst_n),
        .mono_mode    (mono_reg),
        .side_valid   (side_valid),
        .side_ready   (side_ready),
        .side         (side),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire
